>>> hw/rtl/ptt_pkg.sv
package ptt_pkg;

    // Table geometry
    localparam int NUM_TIMERS = 8;
    localparam int KEY_BITS   = 16;
    localparam int TIME_BITS  = 32;
    localparam int SLOT_BITS  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((KEY_BITS + 2 * TIME_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 + KEY_BITS + 7) / 8) * 8;
    localparam int REQ_BITS  = 3;
    localparam int STAT_BITS = 2;

    // Request codes
    localparam logic [REQ_BITS-1:0] REQ_SET     = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR   = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_RESET   = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_RESTART = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_SCAN    = 3'd4;

    // Result status codes
    localparam logic [STAT_BITS-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_FULL      = 2'd2;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_WALK,
        CS_APPLY,
        CS_FINISH
    } ctrl_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic apply;
        logic finish;
    } ptt_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_scan;
        logic walk_done;
        logic stall;
        logic out_free;
    } ptt_stat_t;

endpackage

>>> hw/rtl/periodic_timer_table_top.sv
// Channel | Role   | Handshake          | Payload
// s_      | input  | s_tvalid/s_tready  | tuser: req_type; tdata: key, period, now
// m_      | result | m_tvalid/m_tready  | tuser: expired; tdata: status, key; tlast
//
// Every request walks the whole table, one entry per cycle through a single
// compare unit, except while a scan hit waits on m_tready; the final result
// of each request also waits on m_tready.
// Synchronous active-low reset empties the table; entry payload is not cleared.
// A result waiting in the output register does not block taking the next request.
module periodic_timer_table_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] timer_key, [47:16] period, [79:48] now
    input  logic [ptt_pkg::S_TDATA_W-1:0]    s_tdata,
    // [2:0] req_type
    input  logic [ptt_pkg::REQ_BITS-1:0]     s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status, [17:2] expired_key, rest zero
    output logic [ptt_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] expired
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import ptt_pkg::*;

    ptt_cmd_t             cmd;
    ptt_stat_t            stat;
    logic [STAT_BITS-1:0] res_status;
    logic [KEY_BITS-1:0]  res_key;

    ptt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptt_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_req_type     (s_tuser),
        .in_timer_key    (s_tdata[KEY_BITS-1:0]),
        .in_period       (s_tdata[KEY_BITS+TIME_BITS-1:KEY_BITS]),
        .in_now          (s_tdata[KEY_BITS+2*TIME_BITS-1:KEY_BITS+TIME_BITS]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_status      (res_status),
        .out_expired     (m_tuser),
        .out_expired_key (res_key),
        .out_last        (m_tlast)
    );

    // Pack result fields, zero fill to the byte
    assign m_tdata = M_TDATA_W'({res_key, res_status});

endmodule

>>> hw/rtl/ptt_ctrl.sv
module ptt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ptt_pkg::ptt_stat_t stat,
    output ptt_pkg::ptt_cmd_t  cmd
);
    import ptt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_WALK;
                end
            end
            CS_WALK: begin
                // hold while a scan hit waits for the output register
                if (!stat.stall) begin
                    cmd.step = 1'b1;
                    if (stat.walk_done) begin
                        state_next = stat.is_scan ? CS_FINISH : CS_APPLY;
                    end
                end
            end
            CS_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = CS_FINISH;
            end
            CS_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> stat.out_free)
        else $error("final result issued while output register busy");

    a_load_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == CS_WALK))
        else $error("accepted request did not start a walk");
`endif

endmodule

>>> hw/rtl/ptt_dp.sv
module ptt_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ptt_pkg::ptt_cmd_t                cmd,
    output ptt_pkg::ptt_stat_t               stat,
    input  logic [ptt_pkg::REQ_BITS-1:0]     in_req_type,
    input  logic [ptt_pkg::KEY_BITS-1:0]     in_timer_key,
    input  logic [ptt_pkg::TIME_BITS-1:0]    in_period,
    input  logic [ptt_pkg::TIME_BITS-1:0]    in_now,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ptt_pkg::STAT_BITS-1:0]    out_status,
    output logic                             out_expired,
    output logic [ptt_pkg::KEY_BITS-1:0]     out_expired_key,
    output logic                             out_last
);
    import ptt_pkg::*;

    // Timer table
    logic [NUM_TIMERS-1:0] valid_reg;
    logic [NUM_TIMERS-1:0] valid_next;
    logic [KEY_BITS-1:0]   key_reg      [NUM_TIMERS];
    logic [TIME_BITS-1:0]  start_reg    [NUM_TIMERS];
    logic [TIME_BITS-1:0]  interval_reg [NUM_TIMERS];

    // Latched request
    logic [REQ_BITS-1:0]   req_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [TIME_BITS-1:0]  req_per_reg;
    logic [TIME_BITS-1:0]  req_now_reg;

    // Walk state
    logic [SLOT_BITS-1:0]  idx_reg;
    logic                  found_reg;
    logic [SLOT_BITS-1:0]  found_slot_reg;
    logic                  free_found_reg;
    logic [SLOT_BITS-1:0]  free_slot_reg;
    logic [TIME_BITS-1:0]  match_start_reg;
    logic [TIME_BITS-1:0]  match_int_reg;
    logic                  hit_valid_reg;
    logic [KEY_BITS-1:0]   hit_key_reg;
    logic [STAT_BITS-1:0]  status_reg;
    logic [STAT_BITS-1:0]  status_next;

    // Output register
    logic                  m_valid_reg;
    logic [STAT_BITS-1:0]  m_status_reg;
    logic                  m_expired_reg;
    logic [KEY_BITS-1:0]   m_key_reg;
    logic                  m_last_reg;

    logic                  is_scan;
    logic                  cur_valid;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  cur_expired;
    logic                  key_hit;
    logic                  out_free;
    logic                  push_mid;
    logic                  use_found;
    logic                  can_place;
    logic [SLOT_BITS-1:0]  target;
    logic [TIME_BITS-1:0]  reset_start;

    // Examine the entry under the walk pointer
    always_comb begin
        is_scan     = (req_reg == REQ_SCAN);
        cur_valid   = valid_reg[idx_reg];
        elapsed     = req_now_reg - start_reg[idx_reg];
        cur_expired = cur_valid && (elapsed >= interval_reg[idx_reg]);
        key_hit     = cur_valid && (key_reg[idx_reg] == req_key_reg);
        out_free    = !m_valid_reg || out_ready;
        push_mid    = cmd.step && is_scan && cur_expired && hit_valid_reg;
    end

    // Slot choice for set: lowest of the matching slot and the first free one
    always_comb begin
        use_found   = found_reg && (!free_found_reg || (found_slot_reg < free_slot_reg));
        can_place   = found_reg || free_found_reg;
        target      = use_found ? found_slot_reg : free_slot_reg;
        reset_start = match_start_reg + match_int_reg;
        priority case (req_reg)
            REQ_SET:     status_next = can_place ? STAT_OK : STAT_FULL;
            REQ_CLEAR,
            REQ_RESET,
            REQ_RESTART: status_next = found_reg ? STAT_OK : STAT_NOT_FOUND;
            default:     status_next = STAT_OK;
        endcase
        // Valid bits after the apply step; set drops the old slot then claims the target
        valid_next = valid_reg;
        if (cmd.apply) begin
            if (req_reg == REQ_SET) begin
                if (found_reg) begin
                    valid_next[found_slot_reg] = 1'b0;
                end
                if (can_place) begin
                    valid_next[target] = 1'b1;
                end
            end else if (req_reg == REQ_CLEAR && found_reg) begin
                valid_next[found_slot_reg] = 1'b0;
            end
        end
    end

    always_comb begin
        stat.is_scan   = is_scan;
        stat.walk_done = (idx_reg == SLOT_BITS'(NUM_TIMERS - 1));
        stat.stall     = is_scan && cur_expired && hit_valid_reg && !out_free;
        stat.out_free  = out_free;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            hit_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                hit_valid_reg  <= 1'b0;
            end
            if (cmd.step) begin
                if (!is_scan && key_hit && !found_reg) begin
                    found_reg <= 1'b1;
                end
                if (!cur_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
                if (is_scan && cur_expired) begin
                    hit_valid_reg <= 1'b1;
                end
            end
            valid_reg <= valid_next;
            if (push_mid || cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg     <= in_req_type;
            req_key_reg <= in_timer_key;
            req_per_reg <= in_period;
            req_now_reg <= in_now;
            idx_reg     <= '0;
        end
        if (cmd.step) begin
            idx_reg <= idx_reg + SLOT_BITS'(1);
            if (!is_scan && key_hit && !found_reg) begin
                found_slot_reg  <= idx_reg;
                match_start_reg <= start_reg[idx_reg];
                match_int_reg   <= interval_reg[idx_reg];
            end
            if (!cur_valid && !free_found_reg) begin
                free_slot_reg <= idx_reg;
            end
            if (is_scan && cur_expired) begin
                hit_key_reg <= key_reg[idx_reg];
            end
        end
        if (cmd.apply) begin
            status_reg <= status_next;
            if (req_reg == REQ_SET && can_place) begin
                key_reg[target]      <= req_key_reg;
                start_reg[target]    <= req_now_reg;
                interval_reg[target] <= req_per_reg;
            end else if (req_reg == REQ_RESET && found_reg) begin
                start_reg[found_slot_reg] <= reset_start;
            end else if (req_reg == REQ_RESTART && found_reg) begin
                start_reg[found_slot_reg] <= req_now_reg;
            end
        end
        // Result register
        if (push_mid) begin
            m_status_reg  <= STAT_OK;
            m_expired_reg <= 1'b1;
            m_key_reg     <= hit_key_reg;
            m_last_reg    <= 1'b0;
        end else if (cmd.finish) begin
            m_status_reg  <= is_scan ? STAT_OK : status_reg;
            m_expired_reg <= is_scan && hit_valid_reg;
            m_key_reg     <= (is_scan && hit_valid_reg) ? hit_key_reg : '0;
            m_last_reg    <= 1'b1;
        end
    end

    assign out_valid       = m_valid_reg;
    assign out_status      = m_status_reg;
    assign out_expired     = m_expired_reg;
    assign out_expired_key = m_key_reg;
    assign out_last        = m_last_reg;

`ifndef NO_ASSERTIONS
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push_mid |-> out_free)
        else $error("scan hit pushed over an unread result");

    a_hit_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_valid_reg |-> (req_reg == REQ_SCAN))
        else $error("pending hit outside a scan");

    a_full_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.apply && (req_reg == REQ_SET) && !can_place) |-> (&valid_reg))
        else $error("set reported full with a free slot");
`endif

endmodule

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 30;
    localparam int RANDOM_PER_PHASE = 60;
    localparam int KEY_POOL_SIZE  = 10;

    // one request as the host issues it
    typedef struct {
        logic [REQ_BITS-1:0]  req_type;
        logic [KEY_BITS-1:0]  timer_key;
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] now;
    } timer_req_t;

    // one result transfer
    typedef struct {
        logic [STAT_BITS-1:0] status;
        logic                 expired;
        logic [KEY_BITS-1:0]  expired_key;
        logic                 last;
    } timer_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [REQ_BITS-1:0]   s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    periodic_timer_table_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // stimulus and scoreboard state
    timer_req_t    pending_reqs[$];
    timer_result_t expected_results[$];
    int            queued_cnt   = 0;
    int            accepted_cnt = 0;
    int            err_cnt      = 0;
    int            src_idle_pct = 0;
    int            snk_idle_pct = 0;
    bit            hold_request = 1'b0;
    bit            hold_done    = 1'b0;
    int            hold_left    = 0;
    int            quiet_cycles = 0;

    // coverage-ish tallies for the summary
    int expiry_reports = 0;
    int empty_scans    = 0;
    int full_sets      = 0;
    int missing_keys   = 0;

    // host-side timeline and key pool for random traffic
    logic [TIME_BITS-1:0] host_clock = 32'hFFFF_FF00;
    logic [KEY_BITS-1:0]  key_pool[KEY_POOL_SIZE];

    // shadow copy of the timer table
    logic                 tbl_valid[NUM_TIMERS];
    logic [KEY_BITS-1:0]  tbl_key[NUM_TIMERS];
    logic [TIME_BITS-1:0] tbl_start[NUM_TIMERS];
    logic [TIME_BITS-1:0] tbl_interval[NUM_TIMERS];

    initial begin
        for (int i = 0; i < NUM_TIMERS; i++) tbl_valid[i] = 1'b0;
    end

    // Apply one request to the shadow table and queue the results it yields
    function automatic void predict_timer_results(timer_req_t r);
        timer_result_t res;
        logic [TIME_BITS-1:0] age;
        int slot;
        int hits;
        int seen;
        res.status      = STAT_OK;
        res.expired     = 1'b0;
        res.expired_key = '0;
        res.last        = 1'b1;

        if (r.req_type == REQ_SCAN) begin
            hits = 0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                age = r.now - tbl_start[i];
                if (tbl_valid[i] && age >= tbl_interval[i]) hits++;
            end
            seen = 0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                age = r.now - tbl_start[i];
                if (tbl_valid[i] && age >= tbl_interval[i]) begin
                    seen++;
                    res.expired     = 1'b1;
                    res.expired_key = tbl_key[i];
                    res.last        = (seen == hits);
                    expected_results.push_back(res);
                end
            end
            if (hits == 0) begin
                expected_results.push_back(res);
                empty_scans++;
            end
            expiry_reports += hits;
            return;
        end

        // lowest valid slot holding the key
        slot = -1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (slot < 0 && tbl_valid[i] && tbl_key[i] == r.timer_key) slot = i;
        end

        case (r.req_type)
            REQ_SET: begin
                if (slot >= 0) tbl_valid[slot] = 1'b0;
                slot = -1;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (slot < 0 && !tbl_valid[i]) slot = i;
                end
                if (slot < 0) begin
                    res.status = STAT_FULL;
                    full_sets++;
                end else begin
                    tbl_valid[slot]    = 1'b1;
                    tbl_key[slot]      = r.timer_key;
                    tbl_start[slot]    = r.now;
                    tbl_interval[slot] = r.period;
                end
            end
            REQ_CLEAR, REQ_RESET, REQ_RESTART: begin
                if (slot < 0) begin
                    res.status = STAT_NOT_FOUND;
                    missing_keys++;
                end else if (r.req_type == REQ_CLEAR) begin
                    tbl_valid[slot] = 1'b0;
                end else if (r.req_type == REQ_RESET) begin
                    tbl_start[slot] = tbl_start[slot] + tbl_interval[slot];
                end else begin
                    tbl_start[slot] = r.now;
                end
            end
            default: ;  // unused codes leave the table alone
        endcase
        expected_results.push_back(res);
    endfunction

    function automatic timer_req_t make_req(logic [REQ_BITS-1:0] op, logic [KEY_BITS-1:0] key,
                                            logic [TIME_BITS-1:0] per,
                                            logic [TIME_BITS-1:0] t);
        timer_req_t r;
        r.req_type  = op;
        r.timer_key = key;
        r.period    = per;
        r.now       = t;
        return r;
    endfunction

    // Random request: mostly pool keys, short intervals and an advancing clock
    function automatic timer_req_t random_request();
        timer_req_t r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 24)      r.req_type = REQ_SET;
        else if (pick < 36) r.req_type = REQ_CLEAR;
        else if (pick < 52) r.req_type = REQ_RESET;
        else if (pick < 64) r.req_type = REQ_RESTART;
        else if (pick < 94) r.req_type = REQ_SCAN;
        else                r.req_type = 3'($urandom_range(5, 7));

        if ($urandom_range(99) < 85) r.timer_key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        else                         r.timer_key = 16'($urandom);

        if ($urandom_range(99) < 80) r.period = $urandom_range(0, 120);
        else                         r.period = $urandom;

        host_clock = host_clock + $urandom_range(0, 40);
        if ($urandom_range(99) < 10) r.now = $urandom;
        else                         r.now = host_clock;
        return r;
    endfunction

    task automatic queue_req(timer_req_t r);
        pending_reqs.push_back(r);
        queued_cnt++;
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) queue_req(random_request());
    endtask

    // wait until every request is taken and every result has come back
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Request driver
    always @(posedge aclk) begin
        timer_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                r = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {r.now, r.period, r.timer_key};
                s_tuser  <= r.req_type;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random backpressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Monitor: predict on request transfer, check on result transfer
    always @(posedge aclk) begin
        timer_req_t    r;
        timer_result_t want;
        timer_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                r.timer_key = s_tdata[15:0];
                r.period    = s_tdata[47:16];
                r.now       = s_tdata[79:48];
                r.req_type  = s_tuser;
                predict_timer_results(r);
                accepted_cnt++;
            end
            if (m_tvalid && m_tready) begin
                got.status      = m_tdata[1:0];
                got.expired_key = m_tdata[17:2];
                got.expired     = m_tuser;
                got.last        = m_tlast;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer: status %0d expired %0d key %h last %0d",
                           got.status, got.expired, got.expired_key, got.last);
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        err_cnt++;
                    end
                    if (got.expired !== want.expired) begin
                        $error("expired mismatch: expected %0d, actual %0d",
                               want.expired, got.expired);
                        err_cnt++;
                    end
                    if (got.expired_key !== want.expired_key) begin
                        $error("expired_key mismatch: expected %h, actual %h",
                               want.expired_key, got.expired_key);
                        err_cnt++;
                    end
                    if (got.last !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               want.last, got.last);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else                                                  quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = 16'($urandom);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // phase 1: sender idles 30%, receiver 64%
        src_idle_pct = 30;
        snk_idle_pct = 64;

        // empty table, missing keys
        queue_req(make_req(REQ_SCAN, 16'h0000, 32'h0, 32'h0));
        queue_req(make_req(REQ_CLEAR, 16'h1234, 32'h0, 32'h0));
        queue_req(make_req(REQ_RESET, 16'h1234, 32'h0, 32'h0));
        queue_req(make_req(REQ_RESTART, 16'h1234, 32'h0, 32'h0));
        // zero interval, maximal interval, start just before wrap
        queue_req(make_req(REQ_SET, 16'h0000, 32'h0, 32'hFFFF_FFF0));
        queue_req(make_req(REQ_SET, 16'hFFFF, 32'hFFFF_FFFF, 32'h0));
        queue_req(make_req(REQ_SET, 16'h0001, 32'h20, 32'hFFFF_FFF0));
        // age computed across the wrap
        queue_req(make_req(REQ_SCAN, 16'h0000, 32'h0, 32'h10));
        queue_req(make_req(REQ_RESET, 16'h0001, 32'h0, 32'h0));
        queue_req(make_req(REQ_RESTART, 16'hFFFF, 32'h0, 32'hFFFF_FFFF));
        // replace an existing key
        queue_req(make_req(REQ_SET, 16'h0000, 32'h5, 32'h10));
        // fill the table
        for (int k = 2; k <= 6; k++)
            queue_req(make_req(REQ_SET, 16'(k), 32'(k * 3), 32'(16 + k)));
        // set on full table, then replace on full table
        queue_req(make_req(REQ_SET, 16'h00AA, 32'h1, 32'h20));
        queue_req(make_req(REQ_SET, 16'h0003, 32'h0, 32'h20));
        // unused request codes
        for (int c = 5; c <= 7; c++)
            queue_req(make_req(3'(c), 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // scan with many hits, then drop one and scan again
        queue_req(make_req(REQ_SCAN, 16'h0000, 32'h0, 32'hFFFF_FFFF));
        queue_req(make_req(REQ_CLEAR, 16'h0000, 32'h0, 32'h0));
        queue_req(make_req(REQ_SCAN, 16'h0000, 32'h0, 32'h40));

        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // phase 2: sender idles 64%, receiver 30%
        src_idle_pct = 64;
        snk_idle_pct = 30;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // phase 3: no idling, one long receiver hold-off to back up the input
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random(RANDOM_PER_PHASE);
        hold_request = 1'b1;
        wait_drained();

        $display("Ran %0d requests over three idle profiles and one long output stall.",
                 accepted_cnt);
        $display("Saw %0d expiry reports, %0d empty scans, %0d full-table sets, %0d missing keys.",
                 expiry_reports, empty_scans, full_sets, missing_keys);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ctrl.sv
hw/rtl/ptt_dp.sv
hw/rtl/periodic_timer_table_top.sv
dv/tb_top.sv
